// ===== design/escd_pkg.sv =====
// Shared constants, types and codes for the escaped channel byte demux.
package escd_pkg;

    localparam int CHAN_COUNT = 4;
    localparam int CHAN_W     = 2;
    localparam int FIFO_DEPTH = 256;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int DROP_W   = 16;
    localparam int FILL_W   = 9;

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W     = CNT_W + 1;
    localparam int RAM_DEPTH = CHAN_COUNT * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [BYTE_W-1:0] ESC_CODE = 8'hCE;
    localparam logic [BYTE_W-1:0] SEL_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] SEL_BASE = 8'hC0;
    localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED      = 3'd0,
        ST_CONTROL     = 3'd1,
        ST_NOCHAN      = 3'd2,
        ST_FULL        = 3'd3,
        ST_READ        = 3'd4,
        ST_EMPTY       = 3'd5,
        ST_EMPTY_DROPS = 3'd6,
        ST_CLEARED     = 3'd7
    } status_t;

    // Byte store access issued by the control logic.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Result metadata; the popped byte joins it from the store's registered read.
    typedef struct packed {
        status_t           status;
        logic [DROP_W-1:0] drop_count;
        logic [FILL_W-1:0] fill;
    } rsp_t;

endpackage

// ===== design/escd_if.sv =====
// Valid/ready channel interfaces for input words and result words.
interface escd_item_if;
    logic                        valid;
    logic                        ready;
    logic [escd_pkg::CMD_W-1:0]  cmd;
    logic [escd_pkg::BYTE_W-1:0] data_byte;
    logic [escd_pkg::CHAN_W-1:0] channel;

    modport source (output valid, output cmd, output data_byte, output channel, input ready);
    modport sink   (input valid, input cmd, input data_byte, input channel, output ready);
endinterface

interface escd_result_if;
    logic                          valid;
    logic                          ready;
    logic [escd_pkg::STATUS_W-1:0] status;
    logic [escd_pkg::BYTE_W-1:0]   out_byte;
    logic [escd_pkg::DROP_W-1:0]   drop_count;
    logic [escd_pkg::FILL_W-1:0]   fill;

    modport source (output valid, output status, output out_byte, output drop_count,
                    output fill, input ready);
    modport sink   (input valid, input status, input out_byte, input drop_count,
                    input fill, output ready);
endinterface

// ===== design/escaped_channel_byte_demux.sv =====
// Top level: four-channel byte-stuffing demultiplexer with shared byte store.
//
//   channel   dir   fields                               word
//   items     in    cmd[1:0] data_byte[7:0] channel[1:0] carrier byte / read / clear
//   results   out   status[2:0] out_byte[7:0]            one per word, none for
//                   drop_count[15:0] fill[8:0]           unused cmd 3
//
// One word per cycle sustained while the sink keeps up. A word is decoded and
// its channel pointers updated in the cycle it is accepted; the byte store is
// written or read at that edge and the read byte is merged one stage later.
// Reset clears selection, escape, pointers and drop counters at once; the
// store itself needs no clearing since only written slots are ever read. A
// stalled sink backs up the two result stages, and items.ready drops only
// when both are full.
module escaped_channel_byte_demux (
    input  logic          clk,
    input  logic          rst_n,
    escd_item_if.sink     items,
    escd_result_if.source results
);
    import escd_pkg::*;

    logic              take;
    logic              fire;
    mem_req_t          mem_req;
    logic [BYTE_W-1:0] rd_data;
    logic              rsp_valid;
    rsp_t              rsp;

    // Accept whenever the read stage is free or moving on.
    assign items.ready = take;
    assign fire        = items.valid && take;

    escd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_cmd  (items.cmd),
        .item_byte (items.data_byte),
        .item_chan (items.channel),
        .mem_req   (mem_req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // Writes land at an earlier edge than any later read of the same slot, so no
    // forwarding is needed.
    escd_fifo_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    escd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rsp_valid (rsp_valid && fire),
        .rsp       (rsp),
        .rd_data   (rd_data),
        .take      (take),
        .results   (results)
    );

endmodule

// ===== design/escd_fifo_ram.sv =====
// Byte store shared by the four channel FIFOs: one write, one registered read.
module escd_fifo_ram (
    input  logic                        clk,
    input  escd_pkg::mem_req_t          req,
    output logic [escd_pkg::BYTE_W-1:0] rd_data
);
    import escd_pkg::*;

    logic [BYTE_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read data holds until the next read, so a stalled result keeps its byte.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== design/escd_ctrl.sv =====
// Carrier decode, per-channel FIFO pointers and drop counters, store requests.
module escd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [escd_pkg::CMD_W-1:0]  item_cmd,
    input  logic [escd_pkg::BYTE_W-1:0] item_byte,
    input  logic [escd_pkg::CHAN_W-1:0] item_chan,
    output escd_pkg::mem_req_t          mem_req,
    output logic                        rsp_valid,
    output escd_pkg::rsp_t              rsp
);
    import escd_pkg::*;

    logic              esc_reg, esc_next;
    logic              chosen_reg, chosen_next;
    logic [CHAN_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0]  head_reg [CHAN_COUNT];
    logic [PTR_W-1:0]  head_next [CHAN_COUNT];
    logic [CNT_W-1:0]  cnt_reg [CHAN_COUNT];
    logic [CNT_W-1:0]  cnt_next [CHAN_COUNT];
    logic [DROP_W-1:0] drop_reg [CHAN_COUNT];
    logic [DROP_W-1:0] drop_next [CHAN_COUNT];

    logic              is_sel;
    logic              is_esc;
    logic [CHAN_W-1:0] ch_sel;
    logic [PTR_W-1:0]  head_cur, head_new, head_inc;
    logic [CNT_W-1:0]  cnt_cur, cnt_new;
    logic [DROP_W-1:0] drop_cur, drop_new;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail_pos;
    logic [ADDR_W-1:0] chan_base;
    logic              show;
    status_t           st;

    assign is_sel = ((item_byte & SEL_MASK) == SEL_BASE);
    assign is_esc = (item_byte == ESC_CODE);

    always_comb
    begin
        if (cmd_t'(item_cmd) == CMD_BYTE)
        begin
            ch_sel = (!esc_reg && is_sel) ? item_byte[CHAN_W-1:0] : cur_reg;
        end
        else
        begin
            ch_sel = item_chan;
        end
    end

    assign head_cur = head_reg[ch_sel];
    assign cnt_cur  = cnt_reg[ch_sel];
    assign drop_cur = drop_reg[ch_sel];

    // Tail slot: head + count wraps at most once.
    assign tail_sum = SUM_W'(head_cur) + SUM_W'(cnt_cur);
    assign tail_pos = (tail_sum >= SUM_W'(FIFO_DEPTH))
                      ? PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_cur == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_cur + 1'b1;
    assign chan_base = ADDR_W'(ch_sel) * ADDR_W'(FIFO_DEPTH);

    always_comb
    begin
        esc_next    = esc_reg;
        chosen_next = chosen_reg;
        cur_next    = cur_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        head_new    = head_cur;
        cnt_new     = cnt_cur;
        drop_new    = drop_cur;
        show        = 1'b1;
        st          = ST_CONTROL;
        rsp_valid   = 1'b0;
        mem_req     = '0;
        mem_req.wr_addr = chan_base + ADDR_W'(tail_pos);
        mem_req.wr_data = item_byte;
        mem_req.rd_addr = chan_base + ADDR_W'(head_cur);

        case (cmd_t'(item_cmd))
            CMD_BYTE:
            begin
                rsp_valid = fire;
                esc_next  = 1'b0;
                if (!esc_reg && is_sel)
                begin
                    cur_next    = item_byte[CHAN_W-1:0];
                    chosen_next = 1'b1;
                    st          = ST_CONTROL;
                end
                else if (!esc_reg && is_esc)
                begin
                    esc_next = 1'b1;
                    st       = ST_CONTROL;
                    show     = chosen_reg;
                end
                else if (!chosen_reg)
                begin
                    st   = ST_NOCHAN;
                    show = 1'b0;
                end
                else if (cnt_cur != CNT_W'(FIFO_DEPTH))
                begin
                    st            = ST_STORED;
                    cnt_new       = cnt_cur + 1'b1;
                    mem_req.wr_en = fire;
                end
                else
                begin
                    st = ST_FULL;
                    if (drop_cur != DROP_MAX)
                    begin
                        drop_new = drop_cur + 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                rsp_valid = fire;
                if (cnt_cur == '0)
                begin
                    st = (drop_cur != '0) ? ST_EMPTY_DROPS : ST_EMPTY;
                end
                else
                begin
                    st            = ST_READ;
                    head_new      = head_inc;
                    cnt_new       = cnt_cur - 1'b1;
                    mem_req.rd_en = fire;
                end
            end
            CMD_CLEAR:
            begin
                rsp_valid = fire;
                st        = ST_CLEARED;
                head_new  = '0;
                cnt_new   = '0;
                drop_new  = '0;
            end
            default:
            begin
                rsp_valid = 1'b0;
            end
        endcase

        head_next[ch_sel] = head_new;
        cnt_next[ch_sel]  = cnt_new;
        drop_next[ch_sel] = drop_new;

        rsp.status     = st;
        rsp.drop_count = show ? drop_new : '0;
        rsp.fill       = show ? FILL_W'(cnt_new) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            chosen_reg <= 1'b0;
            cur_reg    <= '0;
            for (int i = 0; i < CHAN_COUNT; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
                drop_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            esc_reg    <= esc_next;
            chosen_reg <= chosen_next;
            cur_reg    <= cur_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

// ===== design/escd_out_stage.sv =====
// Result pipeline: store-read stage, then the output register facing the sink.
module escd_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rsp_valid,
    input  escd_pkg::rsp_t              rsp,
    input  logic [escd_pkg::BYTE_W-1:0] rd_data,
    output logic                        take,
    escd_result_if.source               results
);
    import escd_pkg::*;

    logic              s1_valid_reg;
    rsp_t              s1_rsp_reg;
    logic              s1_adv;
    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [DROP_W-1:0] out_drop_reg;
    logic [FILL_W-1:0] out_fill_reg;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || results.ready);
    assign take   = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= rsp_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && rsp_valid)
        begin
            s1_rsp_reg <= rsp;
        end
        if (s1_adv)
        begin
            out_status_reg <= s1_rsp_reg.status;
            out_byte_reg   <= (s1_rsp_reg.status == ST_READ) ? rd_data : '0;
            out_drop_reg   <= s1_rsp_reg.drop_count;
            out_fill_reg   <= s1_rsp_reg.fill;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.status     = out_status_reg;
    assign results.out_byte   = out_byte_reg;
    assign results.drop_count = out_drop_reg;
    assign results.fill       = out_fill_reg;

endmodule
